[src/sorted_insert_table_macros.svh]
// ----------------------------------------------------------------------------
// Sorted insert table assertion macros
// Shared property forms for the checker of the sorted insert table.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_TABLE_MACROS_SVH
`define SORTED_INSERT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_insert_table: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_insert_table: next-cycle check failed");

`endif

[src/sit_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted insert table package
// Sizes, command and status codes, and the cell control type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int STAT_W   = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/sorted_insert_table.sv]
// ----------------------------------------------------------------------------
// Sorted insert table
// Bounded table of signed keys with payload words, kept in ascending order.
// ----------------------------------------------------------------------------
// An insert request answers in the next cycle with the new count, or with
// the full status when all 32 cells hold entries; a new request may follow
// in every cycle while busy is low. A read request keeps busy high while it
// presents the entries in order, one per cycle, because the chain of cells
// rotates by one place per cycle and the head cell supplies each result. A
// read of an empty table answers in the next cycle with the empty status.
// Results carry out_strobe for exactly one cycle and cannot be held off by
// the receiver.
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_table (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic signed [sit_pkg::KEY_W-1:0] in_key,
  input  wire logic [sit_pkg::PAY_W-1:0]     in_payload,
  output logic                               out_strobe,
  output logic signed [sit_pkg::KEY_W-1:0]   out_key,
  output logic [sit_pkg::PAY_W-1:0]          out_payload,
  output logic [sit_pkg::CNT_W-1:0]          out_entry_count,
  output logic [sit_pkg::STAT_W-1:0]         out_status,
  output logic                               out_last_of_run
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t                             state_r;
  logic [sit_pkg::CNT_W-1:0]          count_r;
  logic [sit_pkg::IDX_W-1:0]          rd_idx_r;
  logic                               out_strobe_r;
  logic signed [sit_pkg::KEY_W-1:0]   out_key_r;
  logic [sit_pkg::PAY_W-1:0]          out_payload_r;
  logic [sit_pkg::CNT_W-1:0]          out_entry_count_r;
  logic [sit_pkg::STAT_W-1:0]         out_status_r;
  logic                               out_last_of_run_r;

  logic                               accept;
  logic                               full;
  logic                               rd_last;
  sit_pkg::cell_ctl_t                 ctl;

  logic                               valid_w [sit_pkg::CAPACITY];
  logic                               move_w  [sit_pkg::CAPACITY];
  logic signed [sit_pkg::KEY_W-1:0]   key_w   [sit_pkg::CAPACITY];
  logic [sit_pkg::PAY_W-1:0]          pay_w   [sit_pkg::CAPACITY];

  assign busy    = (state_r == S_READ);
  assign accept  = start && !busy;
  assign full    = (count_r == sit_pkg::CNT_W'(sit_pkg::CAPACITY));
  assign rd_last = ((sit_pkg::CNT_W'(rd_idx_r) + sit_pkg::CNT_W'(1)) == count_r);

  assign ctl.ins = accept && (in_command == sit_pkg::CMD_INSERT) && !full;
  assign ctl.rot = (state_r == S_READ);

  for (genvar g = 0; g < sit_pkg::CAPACITY; g++) begin : g_cell
    logic                             l_valid;
    logic                             l_move;
    logic signed [sit_pkg::KEY_W-1:0] l_key;
    logic [sit_pkg::PAY_W-1:0]        l_pay;
    logic                             r_valid;
    logic signed [sit_pkg::KEY_W-1:0] r_key;
    logic [sit_pkg::PAY_W-1:0]        r_pay;

    if (g == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_move  = 1'b0;
      assign l_key   = in_key;
      assign l_pay   = in_payload;
    end else begin : g_inner_l
      assign l_valid = valid_w[g-1];
      assign l_move  = move_w[g-1];
      assign l_key   = key_w[g-1];
      assign l_pay   = pay_w[g-1];
    end

    if (g == sit_pkg::CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_key   = key_w[0];
      assign r_pay   = pay_w[0];
    end else begin : g_inner_r
      assign r_valid = valid_w[g+1];
      assign r_key   = key_w[g+1];
      assign r_pay   = pay_w[g+1];
    end

    sit_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_key     (in_key),
      .new_pay     (in_payload),
      .head_key    (key_w[0]),
      .head_pay    (pay_w[0]),
      .left_valid  (l_valid),
      .left_move   (l_move),
      .left_key    (l_key),
      .left_pay    (l_pay),
      .right_valid (r_valid),
      .right_key   (r_key),
      .right_pay   (r_pay),
      .valid       (valid_w[g]),
      .move        (move_w[g]),
      .key         (key_w[g]),
      .pay         (pay_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      count_r           <= '0;
      rd_idx_r          <= '0;
      out_strobe_r      <= 1'b0;
      out_key_r         <= '0;
      out_payload_r     <= '0;
      out_entry_count_r <= '0;
      out_status_r      <= sit_pkg::ST_OK;
      out_last_of_run_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_command == sit_pkg::CMD_INSERT) begin
              out_strobe_r      <= 1'b1;
              out_key_r         <= '0;
              out_payload_r     <= '0;
              out_last_of_run_r <= 1'b1;
              if (full) begin
                out_entry_count_r <= count_r;
                out_status_r      <= sit_pkg::ST_FULL;
              end else begin
                count_r           <= count_r + sit_pkg::CNT_W'(1);
                out_entry_count_r <= count_r + sit_pkg::CNT_W'(1);
                out_status_r      <= sit_pkg::ST_OK;
              end
            end else if (count_r == '0) begin
              out_strobe_r      <= 1'b1;
              out_key_r         <= '0;
              out_payload_r     <= '0;
              out_entry_count_r <= '0;
              out_status_r      <= sit_pkg::ST_EMPTY;
              out_last_of_run_r <= 1'b1;
            end else begin
              state_r  <= S_READ;
              rd_idx_r <= '0;
            end
          end
        end
        S_READ: begin
          out_strobe_r      <= 1'b1;
          out_key_r         <= key_w[0];
          out_payload_r     <= pay_w[0];
          out_entry_count_r <= count_r;
          out_status_r      <= sit_pkg::ST_OK;
          out_last_of_run_r <= rd_last;
          if (rd_last) begin
            state_r <= S_IDLE;
          end else begin
            rd_idx_r <= rd_idx_r + sit_pkg::IDX_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_key         = out_key_r;
  assign out_payload     = out_payload_r;
  assign out_entry_count = out_entry_count_r;
  assign out_status      = out_status_r;
  assign out_last_of_run = out_last_of_run_r;

endmodule

`default_nettype wire

[src/sit_cell.sv]
// ----------------------------------------------------------------------------
// Sorted insert table cell
// Holds one entry; shifts right on insert and rotates left on readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sit_cell (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire sit_pkg::cell_ctl_t            ctl,
  input  wire logic signed [sit_pkg::KEY_W-1:0] new_key,
  input  wire logic [sit_pkg::PAY_W-1:0]     new_pay,
  input  wire logic signed [sit_pkg::KEY_W-1:0] head_key,
  input  wire logic [sit_pkg::PAY_W-1:0]     head_pay,
  input  wire logic                          left_valid,
  input  wire logic                          left_move,
  input  wire logic signed [sit_pkg::KEY_W-1:0] left_key,
  input  wire logic [sit_pkg::PAY_W-1:0]     left_pay,
  input  wire logic                          right_valid,
  input  wire logic signed [sit_pkg::KEY_W-1:0] right_key,
  input  wire logic [sit_pkg::PAY_W-1:0]     right_pay,
  output logic                               valid,
  output logic                               move,
  output logic signed [sit_pkg::KEY_W-1:0]   key,
  output logic [sit_pkg::PAY_W-1:0]          pay
);

  logic                               valid_r;
  logic signed [sit_pkg::KEY_W-1:0]   key_r;
  logic [sit_pkg::PAY_W-1:0]          pay_r;

  // An empty cell or one whose key is above the new key makes room.
  assign move  = !valid_r || (key_r > new_key);
  assign valid = valid_r;
  assign key   = key_r;
  assign pay   = pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.ins && move) begin
      valid_r <= left_move ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && move) begin
      key_r <= left_move ? left_key : new_key;
      pay_r <= left_move ? left_pay : new_pay;
    end else if (ctl.rot && valid_r) begin
      key_r <= right_valid ? right_key : head_key;
      pay_r <= right_valid ? right_pay : head_pay;
    end
  end

endmodule

`default_nettype wire

[src/sit_checker.sv]
// ----------------------------------------------------------------------------
// Sorted insert table checker
// Port-level properties of the sorted insert table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_table_macros.svh"

module sit_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          in_command,
  input wire logic                          out_strobe,
  input wire logic [sit_pkg::CNT_W-1:0]     out_entry_count,
  input wire logic [sit_pkg::STAT_W-1:0]    out_status,
  input wire logic                          out_last_of_run
);

  logic ins_req;
  logic full_res;
  logic empty_res;
  logic full_cnt;

  assign ins_req   = start && !busy && (in_command == sit_pkg::CMD_INSERT);
  assign full_res  = out_strobe && (out_status == sit_pkg::ST_FULL);
  assign empty_res = out_strobe && (out_status == sit_pkg::ST_EMPTY);
  assign full_cnt  = (out_entry_count == sit_pkg::CNT_W'(sit_pkg::CAPACITY));

  `SIT_ASSERT_NEXT(a_insert_answers, ins_req, out_strobe && out_last_of_run)
  `SIT_ASSERT_NEXT(a_read_streams, busy, out_strobe)
  `SIT_ASSERT_NEXT(a_run_continues, out_strobe && !out_last_of_run, out_strobe)
  `SIT_ASSERT_NOW(a_full_count, full_res, full_cnt)
  `SIT_ASSERT_NOW(a_empty_count, empty_res, out_entry_count == '0)

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_strobe      (out_strobe),
  .out_entry_count (out_entry_count),
  .out_status      (out_status),
  .out_last_of_run (out_last_of_run)
);

`default_nettype wire

[tb/sv/tb_sorted_insert_table.sv]
// ----------------------------------------------------------------------------
// Sorted insert table testbench
// Drives insert and read requests into the table and checks every result
// against an ordered table kept alongside the block. It empties once at
// reset, fills with mixed keys, then keeps running against a full table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_insert_table;

  localparam logic signed [sit_pkg::KEY_W-1:0] KEY_MAX = {1'b0, {(sit_pkg::KEY_W-1){1'b1}}};
  localparam logic signed [sit_pkg::KEY_W-1:0] KEY_MIN = {1'b1, {(sit_pkg::KEY_W-1){1'b0}}};

  typedef struct {
    logic signed [sit_pkg::KEY_W-1:0] key;
    logic [sit_pkg::PAY_W-1:0]        payload;
    logic [sit_pkg::CNT_W-1:0]        count;
    logic [sit_pkg::STAT_W-1:0]       status;
    logic                             last;
  } table_result_t;

  class table_scoreboard;
    logic signed [sit_pkg::KEY_W-1:0] keys [sit_pkg::CAPACITY];
    logic [sit_pkg::PAY_W-1:0]        payloads [sit_pkg::CAPACITY];
    int                               occupancy;
    table_result_t                    awaited [$];
    int                               errors;

    function new();
      occupancy = 0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task note_request(logic cmd, logic signed [sit_pkg::KEY_W-1:0] key,
                      logic [sit_pkg::PAY_W-1:0] payload);
      table_result_t r;
      int pos;
      r.key = '0;
      r.payload = '0;
      r.count = occupancy[sit_pkg::CNT_W-1:0];
      r.status = sit_pkg::ST_OK;
      r.last = 1'b1;
      if (cmd == sit_pkg::CMD_INSERT) begin
        if (occupancy >= sit_pkg::CAPACITY) begin
          r.status = sit_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < occupancy && keys[pos] <= key) pos++;
          for (int i = occupancy; i > pos; i--) begin
            keys[i] = keys[i-1];
            payloads[i] = payloads[i-1];
          end
          keys[pos] = key;
          payloads[pos] = payload;
          occupancy++;
          r.count = occupancy[sit_pkg::CNT_W-1:0];
        end
        awaited.push_back(r);
      end else if (occupancy == 0) begin
        r.status = sit_pkg::ST_EMPTY;
        awaited.push_back(r);
      end else begin
        for (int i = 0; i < occupancy; i++) begin
          r.key = keys[i];
          r.payload = payloads[i];
          r.last = (i == occupancy - 1);
          awaited.push_back(r);
        end
      end
    endtask

    task check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with none pending, key %0d", got.key));
        return;
      end
      want = awaited.pop_front();
      if (got.key !== want.key)
        report($sformatf("key %0d, wanted %0d", got.key, want.key));
      if (got.payload !== want.payload)
        report($sformatf("payload %h, wanted %h", got.payload, want.payload));
      if (got.count !== want.count)
        report($sformatf("count %0d, wanted %0d", got.count, want.count));
      if (got.status !== want.status)
        report($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.last !== want.last)
        report($sformatf("last %b, wanted %b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_command;
  logic signed [sit_pkg::KEY_W-1:0] in_key;
  logic [sit_pkg::PAY_W-1:0] in_payload;
  logic out_strobe;
  logic signed [sit_pkg::KEY_W-1:0] out_key;
  logic [sit_pkg::PAY_W-1:0] out_payload;
  logic [sit_pkg::CNT_W-1:0] out_entry_count;
  logic [sit_pkg::STAT_W-1:0] out_status;
  logic out_last_of_run;

  table_scoreboard tracker = new();

  sorted_insert_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_strobe      (out_strobe),
    .out_key         (out_key),
    .out_payload     (out_payload),
    .out_entry_count (out_entry_count),
    .out_status      (out_status),
    .out_last_of_run (out_last_of_run)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    table_result_t seen;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      seen.key = out_key;
      seen.payload = out_payload;
      seen.count = out_entry_count;
      seen.status = out_status;
      seen.last = out_last_of_run;
      tracker.check_result(seen);
    end
  end

  task automatic send_request(logic cmd, logic signed [sit_pkg::KEY_W-1:0] key,
                              logic [sit_pkg::PAY_W-1:0] payload);
    start <= 1'b1;
    in_command <= cmd;
    in_key <= key;
    in_payload <= payload;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_request(cmd, key, payload);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    in_command <= 1'($urandom);
    in_key <= $urandom;
    in_payload <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    while ($urandom_range(99) < 11) idle_cycles(1);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [sit_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return sit_pkg::KEY_W'($signed($urandom_range(8)) - 4);
      1: return $urandom_range(1) ? KEY_MAX - $urandom_range(1) : KEY_MIN + $urandom_range(1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("tb_sorted_insert_table: errors");
    $finish;
  end

  initial begin
    start <= 1'b0;
    in_command <= sit_pkg::CMD_INSERT;
    in_key <= '0;
    in_payload <= '0;
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(sit_pkg::CMD_READ, '0, '0);
    send_request(sit_pkg::CMD_INSERT, '0, '0);
    send_request(sit_pkg::CMD_READ, '1, '1);
    send_request(sit_pkg::CMD_INSERT, KEY_MAX, '1);
    send_request(sit_pkg::CMD_INSERT, KEY_MIN, 32'hFFFF_FFFF);
    send_request(sit_pkg::CMD_INSERT, -1, 32'h5555_AAAA);
    send_request(sit_pkg::CMD_INSERT, 1, 32'hAAAA_5555);
    send_request(sit_pkg::CMD_INSERT, '0, 32'h0000_0001);
    send_request(sit_pkg::CMD_INSERT, KEY_MAX, 32'h0000_0002);
    send_request(sit_pkg::CMD_INSERT, KEY_MIN, 32'h0000_0003);
    send_request(sit_pkg::CMD_READ, '0, '0);
    idle_cycles(2);
    send_request(sit_pkg::CMD_INSERT, '0, 32'h0000_0004);
    send_request(sit_pkg::CMD_READ, '0, '0);
    drain_results();

    for (int n = 0; n < 300; n++) begin
      if (n == 120) drain_results();
      if (n < 120 || n >= 200) maybe_idle();
      if (tracker.occupancy < sit_pkg::CAPACITY && $urandom_range(3) != 0)
        send_request(sit_pkg::CMD_INSERT, pick_key(), $urandom);
      else if ($urandom_range(1) == 0)
        send_request(sit_pkg::CMD_INSERT, pick_key(), $urandom);
      else
        send_request(sit_pkg::CMD_READ, pick_key(), $urandom);
    end
    drain_results();

    if (tracker.errors == 0) begin
      $display("tb_sorted_insert_table: clean");
    end else begin
      $display("tb_sorted_insert_table: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/sit_pkg.sv
src/sit_cell.sv
src/sorted_insert_table.sv
src/sit_checker.sv
tb/sv/tb_sorted_insert_table.sv
